// ===== src/assert_macros.svh =====
// Assertion macros shared by the particle pool RTL.
// Used by the top level only; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PPU_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define PPU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PPU_ASSERT(lbl, cond, msg)
`define PPU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/ppu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the particle pool engine.
// No dependencies.
package ppu_pkg;

    localparam int POOL_SIZE = 512;
    localparam int POOL_AW   = $clog2(POOL_SIZE);
    localparam int CNT_W     = $clog2(POOL_SIZE + 1);

    localparam logic [POOL_AW:0]   POOL_SIZE_W = (POOL_AW + 1)'(POOL_SIZE);
    localparam logic [POOL_AW:0]   POOL_LAST_W = (POOL_AW + 1)'(POOL_SIZE - 1);
    localparam logic [POOL_AW-1:0] POOL_LAST   = POOL_AW'(POOL_SIZE - 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_ANIMATE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFE_RATE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIZE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIZE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED     = 3'd5;

    localparam logic [15:0] LFSR_SEED  = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS  = 16'hB400;
    // floor(x / 5) == (x * 13108) >> 16 for x below 16384
    localparam logic [13:0] RECIP5     = 14'd13108;
    localparam logic [16:0] VX_ROUND   = 17'd20;
    localparam logic signed [15:0] EMIT_POS_Y = 16'sd179;
    localparam logic signed [15:0] EMIT_POS_Z = 16'sd768;
    localparam logic signed [18:0] VY_LIFT    = 19'sd128;
    localparam logic [16:0] LIFE_DEATH = 17'd32440;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] time_now;
        logic [15:0] time_step;
        logic [8:0]  slot_index;
    } cmd_t;

    typedef struct packed {
        logic        animate_enable;
        logic [19:0] emit_interval;
        logic [15:0] life_rate;
        logic [15:0] min_size;
        logic [15:0] max_size;
        logic [15:0] speed_scale;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] vel_z;
        logic [15:0]        life;
        logic [15:0]        size;
        logic               live;
    } entry_t;

    typedef struct packed {
        logic [9:0]         emitted_count;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [15:0]        particle_size;
        logic               alive;
    } result_t;

    typedef struct packed {
        logic clearing;
        logic pop;
    } back_status_t;

    function automatic logic [15:0] lfsr_step(input logic [15:0] l);
        logic [15:0] n;
        n = {1'b0, l[15:1]};
        if (l[0])
        begin
            n = n ^ LFSR_TAPS;
        end
        return n;
    endfunction

    function automatic logic signed [15:0] sat_s16(input logic signed [20:0] x);
        logic signed [15:0] y;
        if (x > 21'sd32767)
        begin
            y = 16'sh7FFF;
        end
        else if (x < -21'sd32768)
        begin
            y = 16'sh8000;
        end
        else
        begin
            y = x[15:0];
        end
        return y;
    endfunction

    function automatic logic [15:0] sat_u16(input logic signed [21:0] x);
        logic [15:0] y;
        if (x < 22'sd0)
        begin
            y = 16'h0000;
        end
        else if (x > 22'sd65535)
        begin
            y = 16'hFFFF;
        end
        else
        begin
            y = x[15:0];
        end
        return y;
    endfunction

endpackage

// ===== src/ppu_if.sv =====
`timescale 1ns / 1ps
// Request and response channel interfaces of the particle pool engine.
// No dependencies.
interface ppu_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] time_now;
    logic [15:0] time_step;
    logic [8:0]  slot_index;

    modport source (output valid, operation, time_now, time_step, slot_index, input ready);
    modport sink (input valid, operation, time_now, time_step, slot_index, output ready);
endinterface

interface ppu_rsp_if;
    logic               valid;
    logic               ready;
    logic [9:0]         emitted_count;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [15:0]        particle_size;
    logic               alive;

    modport source (output valid, emitted_count, pos_x, pos_y, pos_z, particle_size, alive,
                    input ready);
    modport sink (input valid, emitted_count, pos_x, pos_y, pos_z, particle_size, alive,
                  output ready);
endinterface

// ===== src/ppu_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ppu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ppu_front.sv =====
`timescale 1ns / 1ps
// Front end: takes request beats, decodes the operation and queues commands.
// Depends on ppu_pkg and ppu_if.
module ppu_front (
    input  logic                  clk,
    input  logic                  rst_n,
    ppu_req_if.sink               req,
    input  ppu_pkg::back_status_t status,
    output logic                  cmd_valid,
    output ppu_pkg::cmd_t         cmd
);

    ppu_pkg::cmd_t slot_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          push;
    ppu_pkg::cmd_t in_cmd;

    assign req.ready = !status.clearing && (count_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        in_cmd.op         = req.operation ? ppu_pkg::OP_READ : ppu_pkg::OP_TICK;
        in_cmd.time_now   = req.time_now;
        in_cmd.time_step  = req.time_step;
        in_cmd.slot_index = req.slot_index;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (status.pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !status.pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (!push && status.pop)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== src/ppu_back.sv =====
`timescale 1ns / 1ps
// Back end: emission divider, emitter, integration sweep, reads, result register.
// Depends on ppu_pkg and ppu_ram.
module ppu_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ppu_pkg::cfg_t         cfg,
    input  logic                  cmd_valid,
    input  ppu_pkg::cmd_t         cmd,
    output ppu_pkg::back_status_t status,
    output logic                  res_valid,
    input  logic                  res_ready,
    output ppu_pkg::result_t      res
);

    localparam int AW = ppu_pkg::POOL_AW;
    localparam int CW = ppu_pkg::CNT_W;

    localparam logic [2:0] EM_DRAW_Y = 3'd0;
    localparam logic [2:0] EM_DIV_Y  = 3'd1;
    localparam logic [2:0] EM_DRAW_Z = 3'd2;
    localparam logic [2:0] EM_DIV_Z  = 3'd3;
    localparam logic [2:0] EM_WRITE  = 3'd4;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_EMIT  = 7'b0001000,
        S_SWEEP = 7'b0010000,
        S_READ  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    ppu_pkg::cmd_t    cmd_reg;
    logic [AW:0]      idx_reg;
    logic [31:0]      last_emit_reg;
    logic [AW-1:0]    ring_reg;
    logic [15:0]      lfsr_reg;

    // divider
    logic [31:0]      dvd_reg;
    logic [19:0]      rem_reg;
    logic [19:0]      divisor_reg;
    logic [5:0]       dcnt_reg;
    logic [AW-1:0]    qmod_reg;
    logic [20:0]      trial;
    logic             qbit;
    logic [AW:0]      qmod2;
    logic [AW:0]      ring_sum;
    logic [AW-1:0]    ring_adv;
    logic             div_done;
    logic [CW-1:0]    w_next;

    // emitter
    logic signed [15:0] vx_reg;
    logic signed [15:0] vy_reg;
    logic signed [34:0] prod_reg;
    logic [27:0]        q_reg;
    logic               neg_reg;
    logic [2:0]         sub_reg;
    logic [CW-1:0]      left_reg;
    logic [AW-1:0]      ptr_reg;
    logic [CW-1:0]      count_reg;
    logic [15:0]        lfsr_new;
    logic signed [32:0] rs_prod;
    logic signed [34:0] rs_prod3;
    logic [34:0]        prod_abs;
    logic [27:0]        q_next;
    logic signed [15:0] v_rand;
    logic [16:0]        vx_sum;
    logic [27:0]        vx_prod;

    // sweep pipeline
    logic               sweep_issue;
    logic               sweep_done;
    logic               s1v_reg, s2v_reg, s3v_reg, s4v_reg;
    logic [AW-1:0]      s1_addr_reg, s2_addr_reg, s3_addr_reg, s4_addr_reg;
    ppu_pkg::entry_t    s2_e_reg, s3_e_reg, s4_e_reg;
    logic [15:0]        s2_ll_reg;
    logic [14:0]        s2_inc_reg;
    logic signed [33:0] s3_vf_reg [3];
    logic [16:0]        s3_lp_reg;
    logic signed [35:0] s4_pd_reg [3];
    logic signed [34:0] s4_szp_reg;
    logic [16:0]        s4_lp_reg;
    logic [31:0]        ll;
    logic [31:0]        dtr;
    logic signed [17:0] f_mul;
    logic signed [15:0] s2_vel [3];
    logic signed [33:0] vf [3];
    logic [16:0]        lp;
    logic signed [18:0] vp [3];
    logic signed [35:0] pd [3];
    logic signed [16:0] size_diff;
    logic signed [34:0] szp;
    logic signed [15:0] s4_pos [3];
    logic signed [15:0] new_pos [3];
    logic [15:0]        new_size;
    ppu_pkg::entry_t    sweep_e;
    ppu_pkg::entry_t    emit_e;

    // memory and results
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    ppu_pkg::entry_t    ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    ppu_pkg::entry_t    ram_rdata;
    ppu_pkg::result_t   pend_reg;
    ppu_pkg::result_t   out_reg;
    logic               out_valid_reg;
    logic               out_load;
    logic               pop;
    logic               slot_ok;

    ppu_ram #(
        .WIDTH ($bits(ppu_pkg::entry_t)),
        .DEPTH (ppu_pkg::POOL_SIZE)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pop             = (state_reg == S_IDLE) && cmd_valid;
    assign status.pop      = pop;
    assign status.clearing = (state_reg == S_CLEAR);
    assign res_valid       = out_valid_reg;
    assign res             = out_reg;
    assign out_load        = (state_reg == S_DONE) && (!out_valid_reg || res_ready);
    assign slot_ok         = 32'(cmd_reg.slot_index) < ppu_pkg::POOL_SIZE;

    // ---- divider: one quotient bit a cycle, quotient mod pool size alongside
    assign trial    = {rem_reg, dvd_reg[31]};
    assign qbit     = trial >= {1'b0, divisor_reg};
    assign qmod2    = {qmod_reg, qbit};
    assign div_done = dcnt_reg[5];
    assign ring_sum = {1'b0, ring_reg} + {1'b0, qmod_reg};
    assign ring_adv = (ring_sum >= ppu_pkg::POOL_SIZE_W) ?
                      AW'(ring_sum - ppu_pkg::POOL_SIZE_W) : AW'(ring_sum);
    assign w_next   = (dvd_reg >= 32'(ppu_pkg::POOL_SIZE)) ?
                      CW'(ppu_pkg::POOL_SIZE) : CW'(dvd_reg);

    // ---- emitter arithmetic
    assign lfsr_new = ppu_pkg::lfsr_step(lfsr_reg);
    assign rs_prod  = $signed(lfsr_new) * $signed({1'b0, cfg.speed_scale});
    assign rs_prod3 = 35'(rs_prod) + (35'(rs_prod) <<< 1);
    assign prod_abs = prod_reg[34] ? 35'(-prod_reg) : 35'(prod_reg);
    assign q_next   = prod_abs[33:20] * ppu_pkg::RECIP5;
    assign v_rand   = neg_reg ? -$signed(16'(q_reg[27:16])) : $signed(16'(q_reg[27:16]));
    assign vx_sum   = {1'b0, cfg.speed_scale} + ppu_pkg::VX_ROUND;
    assign vx_prod  = vx_sum[16:3] * ppu_pkg::RECIP5;

    always_comb
    begin
        emit_e       = '0;
        emit_e.pos_y = ppu_pkg::EMIT_POS_Y;
        emit_e.pos_z = ppu_pkg::EMIT_POS_Z;
        emit_e.vel_x = vx_reg;
        emit_e.vel_y = vy_reg;
        emit_e.vel_z = v_rand;
        emit_e.live  = 1'b1;
    end

    // ---- sweep pipeline arithmetic
    assign sweep_issue = (state_reg == S_SWEEP) && (idx_reg < ppu_pkg::POOL_SIZE_W);
    assign sweep_done  = (state_reg == S_SWEEP) && !sweep_issue &&
                         !s1v_reg && !s2v_reg && !s3v_reg && !s4v_reg;
    assign ll          = ram_rdata.life * ram_rdata.life;
    assign dtr         = cmd_reg.time_step * cfg.life_rate;
    assign f_mul       = 18'sd32768 - $signed({2'b00, s2_ll_reg});
    assign lp          = {1'b0, s2_e_reg.life} + {2'b00, s2_inc_reg};
    assign size_diff   = $signed({1'b0, cfg.max_size}) - $signed({1'b0, cfg.min_size});
    assign szp         = size_diff * $signed({1'b0, s3_lp_reg});

    always_comb
    begin
        s2_vel[0] = s2_e_reg.vel_x;
        s2_vel[1] = s2_e_reg.vel_y;
        s2_vel[2] = s2_e_reg.vel_z;
        s4_pos[0] = s4_e_reg.pos_x;
        s4_pos[1] = s4_e_reg.pos_y;
        s4_pos[2] = s4_e_reg.pos_z;
        for (int k = 0; k < 3; k++)
        begin
            vf[k] = s2_vel[k] * f_mul;
            vp[k] = $signed(s3_vf_reg[k][33:15]);
            if (k == 1)
            begin
                vp[k] = vp[k] + ppu_pkg::VY_LIFT;
            end
            pd[k] = vp[k] * $signed({1'b0, cmd_reg.time_step});
            new_pos[k] = ppu_pkg::sat_s16(21'(s4_pos[k]) + 21'($signed(s4_pd_reg[k][35:16])));
        end
        new_size = ppu_pkg::sat_u16($signed({6'b0, cfg.min_size}) +
                                    22'($signed(s4_szp_reg[34:15])));
        sweep_e       = s4_e_reg;
        sweep_e.pos_x = new_pos[0];
        sweep_e.pos_y = new_pos[1];
        sweep_e.pos_z = new_pos[2];
        sweep_e.life  = s4_lp_reg[15:0];
        sweep_e.size  = new_size;
        sweep_e.live  = (s4_lp_reg <= ppu_pkg::LIFE_DEATH);
    end

    // ---- memory port muxing
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = idx_reg[AW-1:0];
        end
        else if ((state_reg == S_EMIT) && (sub_reg == EM_WRITE))
        begin
            ram_we    = 1'b1;
            ram_waddr = ptr_reg;
            ram_wdata = emit_e;
        end
        else if (s4v_reg && s4_e_reg.live)
        begin
            ram_we    = 1'b1;
            ram_waddr = s4_addr_reg;
            ram_wdata = sweep_e;
        end
    end

    always_comb
    begin
        ram_re    = sweep_issue;
        ram_raddr = idx_reg[AW-1:0];
        if (pop && (cmd.op == ppu_pkg::OP_READ))
        begin
            ram_re    = 1'b1;
            ram_raddr = AW'(cmd.slot_index);
        end
    end

    // ---- sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (idx_reg == ppu_pkg::POOL_LAST_W)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.op == ppu_pkg::OP_READ)
                    begin
                        state_next = S_READ;
                    end
                    else if (!cfg.animate_enable)
                    begin
                        state_next = S_DONE;
                    end
                    else if (cmd.time_now >= last_emit_reg)
                    begin
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_SWEEP;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = (dvd_reg != 32'd0) ? S_EMIT : S_SWEEP;
                end
            end
            S_EMIT:
            begin
                if ((sub_reg == EM_WRITE) && (left_reg == CW'(1)))
                begin
                    state_next = S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                if (sweep_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            last_emit_reg <= '0;
            ring_reg      <= '0;
            lfsr_reg      <= ppu_pkg::LFSR_SEED;
            dcnt_reg      <= '0;
            sub_reg       <= EM_DRAW_Y;
            left_reg      <= '0;
            s1v_reg       <= 1'b0;
            s2v_reg       <= 1'b0;
            s3v_reg       <= 1'b0;
            s4v_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            s1v_reg   <= sweep_issue;
            s2v_reg   <= s1v_reg;
            s3v_reg   <= s2v_reg;
            s4v_reg   <= s3v_reg;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                S_IDLE:
                begin
                    if (pop && (cmd.op == ppu_pkg::OP_TICK))
                    begin
                        idx_reg  <= '0;
                        dcnt_reg <= '0;
                        if (!cfg.animate_enable)
                        begin
                            last_emit_reg <= cmd.time_now;
                        end
                    end
                end
                S_DIV:
                begin
                    if (!div_done)
                    begin
                        dcnt_reg <= dcnt_reg + 6'd1;
                    end
                    else if (dvd_reg != 32'd0)
                    begin
                        last_emit_reg <= cmd_reg.time_now;
                        ring_reg      <= ring_adv;
                        left_reg      <= w_next;
                        sub_reg       <= EM_DRAW_Y;
                    end
                end
                S_EMIT:
                begin
                    if ((sub_reg == EM_DRAW_Y) || (sub_reg == EM_DRAW_Z))
                    begin
                        lfsr_reg <= lfsr_new;
                    end
                    if (sub_reg == EM_WRITE)
                    begin
                        left_reg <= left_reg - CW'(1);
                        sub_reg  <= EM_DRAW_Y;
                    end
                    else
                    begin
                        sub_reg <= sub_reg + 3'd1;
                    end
                end
                S_SWEEP:
                begin
                    if (sweep_issue)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_READ, S_DONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // ---- datapath registers
    always_ff @(posedge clk)
    begin
        s1_addr_reg <= idx_reg[AW-1:0];
        s2_addr_reg <= s1_addr_reg;
        s2_e_reg    <= ram_rdata;
        s2_ll_reg   <= ll[31:16];
        s2_inc_reg  <= dtr[31:17];
        s3_addr_reg <= s2_addr_reg;
        s3_e_reg    <= s2_e_reg;
        s3_lp_reg   <= lp;
        s4_addr_reg <= s3_addr_reg;
        s4_e_reg    <= s3_e_reg;
        s4_lp_reg   <= s3_lp_reg;
        s4_szp_reg  <= szp;
        for (int k = 0; k < 3; k++)
        begin
            s3_vf_reg[k] <= vf[k];
            s4_pd_reg[k] <= pd[k];
        end

        if (out_load)
        begin
            out_reg <= pend_reg;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    cmd_reg     <= cmd;
                    pend_reg    <= '0;
                    dvd_reg     <= cmd.time_now - last_emit_reg;
                    rem_reg     <= '0;
                    qmod_reg    <= '0;
                    divisor_reg <= (cfg.emit_interval == 20'd0) ? 20'd1 : cfg.emit_interval;
                    vx_reg      <= $signed(16'(vx_prod[27:16]));
                end
            end
            S_DIV:
            begin
                if (!div_done)
                begin
                    rem_reg  <= qbit ? 20'(trial - {1'b0, divisor_reg}) : trial[19:0];
                    dvd_reg  <= {dvd_reg[30:0], qbit};
                    qmod_reg <= (qmod2 >= ppu_pkg::POOL_SIZE_W) ?
                                AW'(qmod2 - ppu_pkg::POOL_SIZE_W) : AW'(qmod2);
                end
                else
                begin
                    ptr_reg                <= ring_reg;
                    count_reg              <= w_next;
                    pend_reg.emitted_count <= 10'(w_next);
                end
            end
            S_EMIT:
            begin
                unique case (sub_reg)
                    EM_DRAW_Y, EM_DRAW_Z:
                    begin
                        prod_reg <= rs_prod3;
                        if (sub_reg == EM_DRAW_Z)
                        begin
                            vy_reg <= v_rand;
                        end
                    end
                    EM_DIV_Y, EM_DIV_Z:
                    begin
                        q_reg   <= q_next;
                        neg_reg <= prod_reg[34];
                    end
                    EM_WRITE:
                    begin
                        ptr_reg <= (ptr_reg == ppu_pkg::POOL_LAST) ? '0 : ptr_reg + 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_READ:
            begin
                if (slot_ok)
                begin
                    pend_reg.pos_x         <= ram_rdata.pos_x;
                    pend_reg.pos_y         <= ram_rdata.pos_y;
                    pend_reg.pos_z         <= ram_rdata.pos_z;
                    pend_reg.particle_size <= ram_rdata.size;
                    pend_reg.alive         <= ram_rdata.live;
                end
            end
            S_CLEAR, S_SWEEP, S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
        if ((state_reg == S_SWEEP) && sweep_done)
        begin
            pend_reg.emitted_count <= 10'(count_reg);
        end
        if (pop)
        begin
            count_reg <= '0;
        end
    end

endmodule

// ===== src/particle_pool_update_engine.sv =====
`timescale 1ns / 1ps
// Top level of the particle pool engine: config registers, front, back.
// Depends on ppu_pkg, ppu_if, ppu_front, ppu_back and assert_macros.svh.
//
//  port   dir   kind          carries
//  req    in    valid/ready   operation, time_now, time_step, slot_index
//  rsp    out   valid/ready   emitted_count, pos_x/y/z, particle_size, alive
//  cfg_*  in    write only    animate_enable .. speed_scale, index 0..5
//
// Read: slot read in S_READ, then registered. Tick with animation off: straight to DONE.
// Tick: divider if time_now >= last emit; per emitted particle draw Y, divide Y, draw Z,
// divide Z, write; a pool sweep through the pipelined memory (one read, one write port).
// After reset a clearing pass writes all POOL_SIZE entries; req.ready stays low.
// A two-deep command queue keeps taking beats while a result waits on rsp.
`include "assert_macros.svh"

module particle_pool_update_engine (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ppu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ppu_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    ppu_req_if.sink                           req,
    ppu_rsp_if.source                         rsp
);

    ppu_pkg::cfg_t         cfg_reg;
    ppu_pkg::back_status_t status;
    logic                  cmd_valid;
    ppu_pkg::cmd_t         cmd;
    logic                  res_valid;
    ppu_pkg::result_t      res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.animate_enable <= 1'b1;
            cfg_reg.emit_interval  <= 20'd983;
            cfg_reg.life_rate      <= 16'd13107;
            cfg_reg.min_size       <= 16'd4096;
            cfg_reg.max_size       <= 16'd21504;
            cfg_reg.speed_scale    <= 16'd12288;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ppu_pkg::CFG_ANIMATE:   cfg_reg.animate_enable <= cfg_wdata[0];
                ppu_pkg::CFG_INTERVAL:  cfg_reg.emit_interval  <= cfg_wdata;
                ppu_pkg::CFG_LIFE_RATE: cfg_reg.life_rate      <= cfg_wdata[15:0];
                ppu_pkg::CFG_MIN_SIZE:  cfg_reg.min_size       <= cfg_wdata[15:0];
                ppu_pkg::CFG_MAX_SIZE:  cfg_reg.max_size       <= cfg_wdata[15:0];
                ppu_pkg::CFG_SPEED:     cfg_reg.speed_scale    <= cfg_wdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    ppu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .status    (status),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    ppu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .status    (status),
        .res_valid (res_valid),
        .res_ready (rsp.ready),
        .res       (res)
    );

    assign rsp.valid         = res_valid;
    assign rsp.emitted_count = res.emitted_count;
    assign rsp.pos_x         = res.pos_x;
    assign rsp.pos_y         = res.pos_y;
    assign rsp.pos_z         = res.pos_z;
    assign rsp.particle_size = res.particle_size;
    assign rsp.alive         = res.alive;

    `PPU_ASSERT(a_pop_needs_cmd, !status.pop || cmd_valid, "pop from empty queue")
    `PPU_ASSERT(a_no_beat_clearing, !(status.clearing && req.ready), "beat while clearing")
    `PPU_ASSERT_NEXT(a_one_cmd_at_a_time, status.pop, !status.pop, "back took two commands")
    `PPU_ASSERT(a_count_bound, !rsp.valid || rsp.emitted_count <= ppu_pkg::POOL_SIZE_W, "count")

endmodule
